// ----- design/nnrs_pkg.sv -----
// nnrs_pkg: shared types and constants of the nearest-neighbour raster scaler
// used by nnrs_ctrl, nnrs_dp and nearest_neighbor_raster_scaler
// no dependencies
package nnrs_pkg;

   localparam int CFG_W       = 16;
   localparam int NUM_CFG     = 8;
   localparam int DEF_MAX_RUN = 64;
   // rounded numerator 2*(k-a0)*(b1-b0)+|den| and doubled denominator
   localparam int NUM_W       = 38;
   localparam int DEN_W       = 18;

   typedef enum logic [2:0] {
      CSR_SRC_X_FIRST = 3'd0,
      CSR_SRC_X_END   = 3'd1,
      CSR_SRC_Y_FIRST = 3'd2,
      CSR_SRC_Y_END   = 3'd3,
      CSR_DST_X_FIRST = 3'd4,
      CSR_DST_X_END   = 3'd5,
      CSR_DST_Y_FIRST = 3'd6,
      CSR_DST_Y_END   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [15:0] source_row;
      logic signed [15:0] source_col;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         null_value;
      logic               has_null;
      logic               row_end;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic [15:0]        dest_lines;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
      logic [7:0]         out_null;
      logic               out_has_null;
      logic               run_last;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic mul_y;
      logic ksel_next;
      logic div_start;
      logic store_y0;
      logic store_y1;
      logic row_latch;
      logic mul_x;
      logic take_col;
      logic push;
      logic push_last;
      logic end_row;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic row_live;
      logic row_end;
      logic run_more;
      logic x_past;
      logic have_pend;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- design/nnrs_div.sv -----
// nnrs_div: restoring unsigned divider, one quotient bit per cycle
// depends on nothing outside itself
module nnrs_div #(
   parameter int NW = 38,
   parameter int DW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [NW-1:0] quo,
   output logic          rem_nz,
   output logic          done
);
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      rem_sh;
   logic [DW:0]      rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quo    = quo_ff;
   assign rem_nz = |rem_ff;
   assign done   = done_ff;

endmodule

// ----- design/nnrs_ctrl.sv -----
// nnrs_ctrl: sequencer of the scaler, one item at a time
// depends on nnrs_pkg
module nnrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  nnrs_pkg::dp_sts_type sts,
   output nnrs_pkg::dp_cmd_type cmd
);
   import nnrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULY0, ST_DIVY0, ST_WTY0, ST_MULY1, ST_DIVY1, ST_WTY1,
      ST_ROWL, ST_CHECK, ST_XTEST, ST_XMUL, ST_XCMP, ST_EMIT, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.load = 1'b1;
               state_in = ST_MULY0;
            end
         end
         ST_MULY0: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_DIVY0;
         end
         ST_DIVY0: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WTY0;
         end
         ST_WTY0: begin
            if (sts.div_done) begin
               cmd.store_y0 = 1'b1;
               state_in     = ST_MULY1;
            end
         end
         ST_MULY1: begin
            cmd.mul_y     = 1'b1;
            cmd.ksel_next = 1'b1;
            state_in      = ST_DIVY1;
         end
         ST_DIVY1: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WTY1;
         end
         ST_WTY1: begin
            if (sts.div_done) begin
               cmd.store_y1 = 1'b1;
               state_in     = ST_ROWL;
            end
         end
         ST_ROWL: begin
            cmd.row_latch = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.row_live ? ST_XTEST : ST_FIN;
         end
         ST_XTEST: begin
            if (!sts.run_more) begin
               state_in = ST_FIN;
            end else if (sts.row_end) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_XCMP;
         end
         ST_XCMP: begin
            state_in = sts.x_past ? ST_FIN : ST_EMIT;
         end
         ST_EMIT: begin
            // the previous column goes out once the next one is known
            if (!sts.have_pend || sts.out_free) begin
               cmd.take_col = 1'b1;
               cmd.push     = sts.have_pend;
               state_in     = ST_XTEST;
            end
         end
         ST_FIN: begin
            if (!sts.have_pend || sts.out_free) begin
               cmd.push      = sts.have_pend;
               cmd.push_last = 1'b1;
               cmd.end_row   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = stall_ff;

endmodule

// ----- design/nnrs_dp.sv -----
// nnrs_dp: registers, mapping arithmetic, column cursor and output word
// depends on nnrs_pkg and nnrs_div
module nnrs_dp #(
   parameter int MAX_RUN = nnrs_pkg::DEF_MAX_RUN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [2:0]                   csr_index,
   input  logic [nnrs_pkg::CFG_W-1:0]   csr_wdata,
   input  nnrs_pkg::req_word_type       req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output nnrs_pkg::rsp_word_type       rsp_word,
   input  nnrs_pkg::dp_cmd_type         cmd,
   output nnrs_pkg::dp_sts_type         sts
);
   import nnrs_pkg::*;

   localparam int RUN_W = $clog2(MAX_RUN + 1);

   logic signed [15:0] cfg_ff [NUM_CFG];
   logic signed [15:0] sx0, sx1, sy0, sy1, dx0, dx1, dy0, dy1;
   req_word_type       item_ff;

   // y mapping
   logic signed [16:0] ky, deny, dsuby;
   logic signed [17:0] ksuby, dsubny;
   logic [16:0]        dabsy;
   logic signed [35:0] prody;
   logic signed [35:0] prody_ff;
   logic [16:0]        dabsy_ff;
   logic               dzy_ff;
   logic signed [37:0] n2y;
   logic [NUM_W-1:0]   n2y_abs;
   logic               n2neg_ff;
   logic [NUM_W-1:0]   quo;
   logic               rem_nz;
   logic               div_done;
   logic signed [38:0] qpos, qs;
   logic signed [39:0] ynew;
   logic signed [39:0] y0_ff, y1_ff;
   logic signed [40:0] lines;
   logic               row_live_ff;
   logic [15:0]        lsat_ff;
   logic [15:0]        ysat_ff;

   // x compare
   logic signed [16:0] kx, denx, dsubx;
   logic signed [17:0] dsubnx, rhsf;
   logic [16:0]        dabsx;
   logic signed [18:0] d2x;
   logic signed [35:0] prodx;
   logic signed [37:0] rhsx;
   logic signed [35:0] prodx_ff;
   logic signed [37:0] rhs_ff;
   logic [16:0]        dabsx_ff;
   logic               dzx_ff;
   logic signed [37:0] n2x;
   logic               x_past;

   logic signed [15:0] cursor_ff;
   logic signed [15:0] pend_x_ff;
   logic               have_pend_ff;
   logic [RUN_W-1:0]   run_cnt_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   logic               out_free;

   assign sx0 = cfg_ff[CSR_SRC_X_FIRST];
   assign sx1 = cfg_ff[CSR_SRC_X_END];
   assign sy0 = cfg_ff[CSR_SRC_Y_FIRST];
   assign sy1 = cfg_ff[CSR_SRC_Y_END];
   assign dx0 = cfg_ff[CSR_DST_X_FIRST];
   assign dx1 = cfg_ff[CSR_DST_X_END];
   assign dy0 = cfg_ff[CSR_DST_Y_FIRST];
   assign dy1 = cfg_ff[CSR_DST_Y_END];

   // row k or k+1 onto destination lines
   always_comb begin
      ky     = 17'(item_ff.source_row) + (cmd.ksel_next ? 17'sd1 : 17'sd0);
      ksuby  = 18'(ky) - 18'(sy0);
      deny   = 17'(sy1) - 17'(sy0);
      dsuby  = 17'(dy1) - 17'(dy0);
      dabsy  = deny[16] ? 17'(-deny) : 17'(deny);
      dsubny = deny[16] ? -18'(dsuby) : 18'(dsuby);
      prody  = 36'(ksuby) * 36'(dsubny);
      n2y    = (38'(prody_ff) <<< 1) + $signed({21'd0, dabsy_ff});
      n2y_abs = n2y[37] ? NUM_W'(-n2y) : NUM_W'(n2y);
      qpos   = $signed({1'b0, quo});
      qs     = n2neg_ff ? -(qpos + $signed({38'd0, rem_nz})) : qpos;
      ynew   = dzy_ff ? 40'(dy0) : 40'(dy0) + 40'(qs);
      lines  = 41'(y1_ff) - 41'(y0_ff);
   end

   nnrs_div #(
      .NW(NUM_W),
      .DW(DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(n2y_abs),
      .divisor ({dabsy_ff, 1'b0}),
      .quo     (quo),
      .rem_nz  (rem_nz),
      .done    (div_done)
   );

   // map(cursor) > col, as n2 >= (col - sx0 + 1) * 2|den|
   always_comb begin
      kx     = 17'(cursor_ff) - 17'(dx0);
      denx   = 17'(dx1) - 17'(dx0);
      dsubx  = 17'(sx1) - 17'(sx0);
      dabsx  = denx[16] ? 17'(-denx) : 17'(denx);
      dsubnx = denx[16] ? -18'(dsubx) : 18'(dsubx);
      prodx  = 36'(18'(kx)) * 36'(dsubnx);
      rhsf   = 18'(item_ff.source_col) - 18'(sx0) + 18'sd1;
      d2x    = $signed({1'b0, dabsx, 1'b0});
      rhsx   = 38'(rhsf) * 38'(d2x);
      n2x    = (38'(prodx_ff) <<< 1) + $signed({21'd0, dabsx_ff});
      x_past = dzx_ff ? (sx0 > item_ff.source_col) : (n2x >= rhs_ff);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_SRC_X_FIRST] <= 16'sd0;
         cfg_ff[CSR_SRC_X_END]   <= 16'sd1;
         cfg_ff[CSR_SRC_Y_FIRST] <= 16'sd0;
         cfg_ff[CSR_SRC_Y_END]   <= 16'sd1;
         cfg_ff[CSR_DST_X_FIRST] <= 16'sd0;
         cfg_ff[CSR_DST_X_END]   <= 16'sd1;
         cfg_ff[CSR_DST_Y_FIRST] <= 16'sd0;
         cfg_ff[CSR_DST_Y_END]   <= 16'sd1;
         cursor_ff    <= 16'sd0;
         have_pend_ff <= 1'b0;
         run_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         row_live_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff[csr_index] <= $signed(csr_wdata);
            cursor_ff <= (csr_idx_type'(csr_index) == CSR_DST_X_FIRST)
                         ? $signed(csr_wdata) : dx0;
         end
         if (cmd.load) begin
            run_cnt_ff <= '0;
         end
         if (cmd.row_latch) begin
            row_live_ff <= (lines > 41'sd0);
         end
         if (cmd.take_col) begin
            cursor_ff    <= cursor_ff + 16'sd1;
            run_cnt_ff   <= run_cnt_ff + 1'b1;
            have_pend_ff <= 1'b1;
         end else if (cmd.push) begin
            have_pend_ff <= 1'b0;
         end
         if (cmd.end_row && item_ff.row_end) begin
            cursor_ff <= dx0;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.load) begin
         item_ff <= req_word;
      end
      if (cmd.mul_y) begin
         prody_ff <= prody;
         dabsy_ff <= dabsy;
         dzy_ff   <= (deny == 17'sd0);
      end
      if (cmd.div_start) begin
         n2neg_ff <= n2y[37];
      end
      if (cmd.store_y0) begin
         y0_ff <= ynew;
      end
      if (cmd.store_y1) begin
         y1_ff <= ynew;
      end
      if (cmd.row_latch) begin
         lsat_ff <= (lines > 41'sd65535) ? 16'hFFFF : lines[15:0];
         if (y0_ff < -40'sd32768) begin
            ysat_ff <= 16'h8000;
         end else if (y0_ff > 40'sd32767) begin
            ysat_ff <= 16'h7FFF;
         end else begin
            ysat_ff <= y0_ff[15:0];
         end
      end
      if (cmd.mul_x) begin
         prodx_ff <= prodx;
         rhs_ff   <= rhsx;
         dabsx_ff <= dabsx;
         dzx_ff   <= (denx == 17'sd0);
      end
      if (cmd.take_col) begin
         pend_x_ff <= cursor_ff;
      end
      if (cmd.push) begin
         rsp_ff.dest_x       <= pend_x_ff;
         rsp_ff.dest_y       <= ysat_ff;
         rsp_ff.dest_lines   <= lsat_ff;
         rsp_ff.out_red      <= item_ff.red;
         rsp_ff.out_green    <= item_ff.green;
         rsp_ff.out_blue     <= item_ff.blue;
         rsp_ff.out_null     <= item_ff.has_null ? item_ff.null_value : 8'd0;
         rsp_ff.out_has_null <= item_ff.has_null;
         rsp_ff.run_last     <= cmd.push_last;
      end
   end

   always_comb begin
      sts.div_done  = div_done;
      sts.row_live  = row_live_ff;
      sts.row_end   = item_ff.row_end;
      sts.run_more  = (run_cnt_ff < RUN_W'(MAX_RUN)) && (cursor_ff < dx1);
      sts.x_past    = x_past;
      sts.have_pend = have_pend_ff;
      sts.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- design/nearest_neighbor_raster_scaler.sv -----
// nearest_neighbor_raster_scaler: one source pixel word in, its run of destination pixels out.
// After acceptance, two 38-step divider passes (first and next destination line of the source
// row) come before the first output word. Input words are taken one at a time: the next is
// accepted only once the run of the last has been pushed, and an output stall holds that run.
// Reset: synchronous, clears control state and loads register defaults; no clearing pass.
module nearest_neighbor_raster_scaler #(
   parameter int MAX_RUN = nnrs_pkg::DEF_MAX_RUN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [nnrs_pkg::CFG_W-1:0] csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  nnrs_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output nnrs_pkg::rsp_word_type     rsp_word
);
   import nnrs_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   nnrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   nnrs_dp #(
      .MAX_RUN(MAX_RUN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word),
      .cmd      (cmd),
      .sts      (sts)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !req_stall && !rsp_valid)
      else $error("scaler not idle after reset");

   a_lines_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.dest_lines != 16'd0)
      else $error("output word covers no destination line");

   a_stall_on_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("input stalled without a word taken");

endmodule
